// ===== sv/matrix_inverse_3x3_assert.svh =====
// Assertion macros for the matrix inverse RTL.
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH

`ifndef ASSERT_OFF

// Checks an implication property at every clock edge outside reset.
`define MI3_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("matrix inverse assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MI3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("matrix inverse assertion failed");

`else

`define MI3_ASSERT(label, clk, rst, prop)
`define MI3_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/mi3_pkg.sv =====
// Types, constants and helper functions for the 3x3 matrix inverse.
`default_nettype none

package mi3_pkg;

   // Fixed-point format and derived widths.
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ADJ_W     = PROD_W + 1;
   localparam int PP_W      = ADJ_W;
   localparam int DET_W     = ADJ_W + DATA_W + 1;
   localparam int DM_W      = DET_W - 1;
   localparam int RW        = DM_W + 1;
   localparam int QUO_W     = DATA_W + 1;
   localparam int NUM_SHIFT = 2 * FRAC_BITS + 1;
   localparam int NUM_W     = PROD_W + NUM_SHIFT;
   localparam int TOP_W     = NUM_W - QUO_W;
   localparam int SAT_W     = DM_W + 1 - 2 * FRAC_BITS;
   localparam int N_ELEM    = 9;
   localparam int N_PROD    = 18;
   localparam int N_LANE    = 9;

   localparam logic [DATA_W-1:0] NEG_LIMIT = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] POS_LIMIT = {1'b0, {(DATA_W-1){1'b1}}};

   // Operand indexes of the eighteen 2x2 minor products, in pairs per
   // adjugate element (row-major order of the adjugate).
   localparam logic [3:0] PROD_A [N_PROD] =
      '{4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
        4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
   localparam logic [3:0] PROD_B [N_PROD] =
      '{4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
        4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};

   typedef struct packed {
      logic signed [DATA_W-1:0] r0c0;
      logic signed [DATA_W-1:0] r0c1;
      logic signed [DATA_W-1:0] r0c2;
      logic signed [DATA_W-1:0] r1c0;
      logic signed [DATA_W-1:0] r1c1;
      logic signed [DATA_W-1:0] r1c2;
      logic signed [DATA_W-1:0] r2c0;
      logic signed [DATA_W-1:0] r2c1;
      logic signed [DATA_W-1:0] r2c2;
   } mi3_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] inv_r0c0;
      logic signed [DATA_W-1:0] inv_r0c1;
      logic signed [DATA_W-1:0] inv_r0c2;
      logic signed [DATA_W-1:0] inv_r1c0;
      logic signed [DATA_W-1:0] inv_r1c1;
      logic signed [DATA_W-1:0] inv_r1c2;
      logic signed [DATA_W-1:0] inv_r2c0;
      logic signed [DATA_W-1:0] inv_r2c1;
      logic signed [DATA_W-1:0] inv_r2c2;
      logic signed [DATA_W-1:0] determinant;
      logic                     singular;
   } mi3_rsp_type;

   // Adjugate element as magnitude and sign.
   typedef struct packed {
      logic [PROD_W-1:0] mag;
      logic              neg;
   } mi3_adj_type;

   // One lane of the divider: partial remainder, numerator bits still to
   // shift in, quotient so far, overflow and result sign.
   typedef struct packed {
      logic [RW-1:0]    rem;
      logic [QUO_W-1:0] low;
      logic [QUO_W-1:0] quo;
      logic             ovf;
      logic             neg;
   } mi3_lane_type;

   // Status that rides along with the divider lanes.
   typedef struct packed {
      logic [DATA_W-1:0] det;
      logic              singular;
   } mi3_side_type;

   // Clamp a magnitude to the signed output range and apply the sign.
   function automatic logic [DATA_W-1:0] sat_mag(input logic [SAT_W-1:0] mag,
                                                 input logic ovf, input logic neg);
      logic [SAT_W-1:0]  lim;
      logic [DATA_W-1:0] v;
      lim = neg ? SAT_W'(NEG_LIMIT) : SAT_W'(POS_LIMIT);
      v   = (ovf || (mag > lim)) ? lim[DATA_W-1:0] : mag[DATA_W-1:0];
      return neg ? (DATA_W'(0) - v) : v;
   endfunction

endpackage

`default_nettype wire

// ===== sv/mi3_div.sv =====
// Pipelined restoring divider for the nine inverse elements, one quotient bit per stage.
`default_nettype none

module mi3_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  mi3_pkg::mi3_lane_type lane_in [mi3_pkg::N_LANE],
   input  logic [mi3_pkg::DM_W-1:0] dm_in,
   input  mi3_pkg::mi3_side_type side_in,
   output logic                 out_valid,
   output mi3_pkg::mi3_rsp_type out_data
);
   import mi3_pkg::*;

   mi3_lane_type      lane_d  [QUO_W+1][N_LANE];
   logic [DM_W-1:0]   dm_d    [QUO_W+1];
   mi3_side_type      side_d  [QUO_W+1];
   logic [QUO_W:0]    valid_d;

   assign lane_d[0]  = lane_in;
   assign dm_d[0]    = dm_in;
   assign side_d[0]  = side_in;
   assign valid_d[0] = in_valid;

   // One stage per quotient bit, most significant first.
   for (genvar s = 0; s < QUO_W; s++) begin : g_step
      mi3_lane_type    step_in [N_LANE];
      mi3_lane_type    step_ff [N_LANE];
      logic [DM_W-1:0] dm_ff;
      mi3_side_type    side_ff;
      logic            valid_ff;

      // Shift in the next numerator bit and subtract the divisor if it fits.
      always_comb begin
         logic [RW-1:0] trial;
         logic          ge;
         for (int k = 0; k < N_LANE; k++) begin
            trial = {lane_d[s][k].rem[RW-2:0], lane_d[s][k].low[QUO_W-1]};
            ge    = trial >= {1'b0, dm_d[s]};
            step_in[k].rem = ge ? (trial - {1'b0, dm_d[s]}) : trial;
            step_in[k].low = {lane_d[s][k].low[QUO_W-2:0], 1'b0};
            step_in[k].quo = {lane_d[s][k].quo[QUO_W-2:0], ge};
            step_in[k].ovf = lane_d[s][k].ovf;
            step_in[k].neg = lane_d[s][k].neg;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= valid_d[s];
         end
         if (en) begin
            step_ff <= step_in;
            dm_ff   <= dm_d[s];
            side_ff <= side_d[s];
         end
      end

      assign lane_d[s+1]  = step_ff;
      assign dm_d[s+1]    = dm_ff;
      assign side_d[s+1]  = side_ff;
      assign valid_d[s+1] = valid_ff;
   end

   // Round the quotient to nearest, saturate and sign the results.
   logic [DATA_W-1:0] inv [N_LANE];
   mi3_rsp_type       rsp_in;
   mi3_rsp_type       rsp_ff;
   logic              rsp_valid_ff;

   always_comb begin
      logic [QUO_W:0] rq;
      for (int k = 0; k < N_LANE; k++) begin
         rq     = {1'b0, lane_d[QUO_W][k].quo} + (QUO_W+1)'(1);
         inv[k] = side_d[QUO_W].singular ? '0 :
                  sat_mag(SAT_W'(rq[QUO_W:1]), lane_d[QUO_W][k].ovf,
                          lane_d[QUO_W][k].neg);
      end
      rsp_in.inv_r0c0    = inv[0];
      rsp_in.inv_r0c1    = inv[1];
      rsp_in.inv_r0c2    = inv[2];
      rsp_in.inv_r1c0    = inv[3];
      rsp_in.inv_r1c1    = inv[4];
      rsp_in.inv_r1c2    = inv[5];
      rsp_in.inv_r2c0    = inv[6];
      rsp_in.inv_r2c1    = inv[7];
      rsp_in.inv_r2c2    = inv[8];
      rsp_in.determinant = side_d[QUO_W].det;
      rsp_in.singular    = side_d[QUO_W].singular;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= valid_d[QUO_W];
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/matrix_inverse_3x3.sv =====
// Top level of the pipelined 3x3 matrix inverse.
//
// Usage: one 3x3 matrix of signed Q16.16 elements enters on the req_ channel
// per transaction; one transaction on the rsp_ channel returns the nine
// inverse elements, the determinant and a singular flag, in input order.
// A transaction completes at a clock edge where valid is high and stall low.
// An accepted matrix passes through registered stages in order: seven stages form
// the products, adjugate, determinant and divisor, 33 stages each produce one
// quotient bit of the nine divisions, and one stage rounds and saturates.
// The first stage loads at the accepting edge unless the pipeline is frozen.
// Throughput is one matrix per cycle while the output is not stalled.
// When rsp_stall holds a waiting result, the whole pipeline freezes and a
// one-entry input buffer still takes one more transaction; req_stall rises
// only while that buffer is full, and it comes straight from a register.
// Synchronous reset empties the pipeline and the input buffer; no result is
// presented until new matrices arrive. A matrix with a zero determinant
// returns singular set and all other fields zero.
`default_nettype none
`include "matrix_inverse_3x3_assert.svh"

module matrix_inverse_3x3 (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mi3_pkg::mi3_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mi3_pkg::mi3_rsp_type rsp_data
);
   import mi3_pkg::*;

   // Pipeline advance and input skid buffer.
   logic        adv;
   logic        req_acc;
   logic        skid_valid_ff;
   logic        skid_valid_in;
   mi3_req_type skid_data_ff;
   mi3_req_type s0_data;
   logic        s0_valid;

   assign adv           = !rsp_valid || !rsp_stall;
   assign req_stall     = skid_valid_ff;
   assign req_acc       = req_valid && !skid_valid_ff;
   assign s0_valid      = skid_valid_ff || req_acc;
   assign s0_data       = skid_valid_ff ? skid_data_ff : req_data;
   assign skid_valid_in = adv ? 1'b0 : (skid_valid_ff || req_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
      if (!adv && req_acc) begin
         skid_data_ff <= req_data;
      end
   end

   // Valid bits of the front stages.
   logic [6:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[5:0], s0_valid};
      end
   end

   // Stage 1: the eighteen 32x32 minor products.
   logic signed [DATA_W-1:0] el [N_ELEM];
   logic signed [PROD_W-1:0] prod_in [N_PROD];
   logic signed [PROD_W-1:0] prod_ff [N_PROD];
   logic signed [DATA_W-1:0] s1_row0_ff [3];

   assign el[0] = s0_data.r0c0;
   assign el[1] = s0_data.r0c1;
   assign el[2] = s0_data.r0c2;
   assign el[3] = s0_data.r1c0;
   assign el[4] = s0_data.r1c1;
   assign el[5] = s0_data.r1c2;
   assign el[6] = s0_data.r2c0;
   assign el[7] = s0_data.r2c1;
   assign el[8] = s0_data.r2c2;

   always_comb begin
      for (int k = 0; k < N_PROD; k++) begin
         prod_in[k] = el[PROD_A[k]] * el[PROD_B[k]];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff    <= prod_in;
         s1_row0_ff <= el[0:2];
      end
   end

   // Stage 2: adjugate elements as differences of product pairs.
   logic signed [ADJ_W-1:0]  adj_in [N_LANE];
   logic signed [ADJ_W-1:0]  adj_ff [N_LANE];
   logic signed [DATA_W-1:0] s2_row0_ff [3];

   always_comb begin
      for (int k = 0; k < N_LANE; k++) begin
         adj_in[k] = ADJ_W'(prod_ff[2*k]) - ADJ_W'(prod_ff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         adj_ff     <= adj_in;
         s2_row0_ff <= s1_row0_ff;
      end
   end

   // Stage 3: row 0 times its cofactors, split into 32x33 partial products.
   logic signed [PP_W-1:0] pl_in [3];
   logic signed [PP_W-1:0] ph_in [3];
   logic signed [PP_W-1:0] pl_ff [3];
   logic signed [PP_W-1:0] ph_ff [3];
   mi3_adj_type            s3_adj_in [N_LANE];
   mi3_adj_type            s3_adj_ff [N_LANE];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         pl_in[j] = PP_W'(s2_row0_ff[j]) * PP_W'($signed({1'b0, adj_ff[3*j][DATA_W-1:0]}));
         ph_in[j] = PP_W'(s2_row0_ff[j]) * PP_W'($signed(adj_ff[3*j][ADJ_W-1:DATA_W]));
      end
      for (int k = 0; k < N_LANE; k++) begin
         s3_adj_in[k].neg = adj_ff[k][ADJ_W-1];
         s3_adj_in[k].mag = adj_ff[k][ADJ_W-1] ? PROD_W'(-adj_ff[k]) : PROD_W'(adj_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff     <= pl_in;
         ph_ff     <= ph_in;
         s3_adj_ff <= s3_adj_in;
      end
   end

   // Stage 4: recombine each partial-product pair.
   logic signed [DET_W-1:0] term_in [3];
   logic signed [DET_W-1:0] term_ff [3];
   mi3_adj_type             s4_adj_ff [N_LANE];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         term_in[j] = (DET_W'(ph_ff[j]) <<< DATA_W) + DET_W'(pl_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         term_ff   <= term_in;
         s4_adj_ff <= s3_adj_ff;
      end
   end

   // Stage 5: exact determinant.
   logic signed [DET_W-1:0] det_ff;
   mi3_adj_type             s5_adj_ff [N_LANE];

   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff    <= term_ff[0] + term_ff[1] + term_ff[2];
         s5_adj_ff <= s4_adj_ff;
      end
   end

   // Stage 6: determinant magnitude, sign and zero test.
   logic [DM_W-1:0] s6_dm_ff;
   logic            s6_dneg_ff;
   logic            s6_zero_ff;
   mi3_adj_type     s6_adj_ff [N_LANE];

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_dm_ff   <= det_ff[DET_W-1] ? DM_W'(-det_ff) : DM_W'(det_ff);
         s6_dneg_ff <= det_ff[DET_W-1];
         s6_zero_ff <= (det_ff == '0);
         s6_adj_ff  <= s5_adj_ff;
      end
   end

   // Stage 7: rounded determinant output and divider lane setup.
   logic [DM_W:0]     det_rnd;
   mi3_side_type      s7_side_in;
   mi3_side_type      s7_side_ff;
   mi3_lane_type      s7_lane_in [N_LANE];
   mi3_lane_type      s7_lane_ff [N_LANE];
   logic [DM_W-1:0]   s7_dm_ff;

   always_comb begin
      logic [NUM_W-1:0] num;
      logic [TOP_W-1:0] top;
      det_rnd = {1'b0, s6_dm_ff} + ((DM_W+1)'(1) << (2 * FRAC_BITS - 1));
      s7_side_in.singular = s6_zero_ff;
      s7_side_in.det      = s6_zero_ff ? '0 :
                            sat_mag(det_rnd[DM_W:2*FRAC_BITS], 1'b0, s6_dneg_ff);
      for (int k = 0; k < N_LANE; k++) begin
         num = {s6_adj_ff[k].mag, {NUM_SHIFT{1'b0}}};
         top = num[NUM_W-1:QUO_W];
         s7_lane_in[k].rem = RW'(top);
         s7_lane_in[k].low = num[QUO_W-1:0];
         s7_lane_in[k].quo = '0;
         s7_lane_in[k].ovf = RW'(top) >= RW'(s6_dm_ff);
         s7_lane_in[k].neg = s6_adj_ff[k].neg ^ s6_dneg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_side_ff <= s7_side_in;
         s7_lane_ff <= s7_lane_in;
         s7_dm_ff   <= s6_dm_ff;
      end
   end

   // Division pipeline and output register.
   mi3_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (valid_ff[6]),
      .lane_in   (s7_lane_ff),
      .dm_in     (s7_dm_ff),
      .side_in   (s7_side_ff),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   // The skid buffer fills only while the pipeline is frozen.
   `MI3_ASSERT(a_skid_only_on_stall, clock, reset, skid_valid_ff |-> $past(!adv))
   // A transaction taken during a freeze must be parked in the skid buffer.
   `MI3_ASSERT_NEXT(a_skid_capture, clock, reset, req_valid && !req_stall && !adv, req_stall)
   // A singular result carries a zero determinant and zero diagonal inverse elements.
   `MI3_ASSERT(a_singular_zero, clock, reset, rsp_valid && rsp_data.singular |-> rsp_data.determinant == '0 && rsp_data.inv_r0c0 == '0 && rsp_data.inv_r1c1 == '0 && rsp_data.inv_r2c2 == '0)

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the 3x3 fixed-point matrix inverse.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mi3_pkg::*;

   localparam int  N_RANDOM    = 1830;
   localparam int  CYCLE_LIMIT = 600000;
   localparam int  DRAIN_WAIT  = 60;
   localparam logic [31:0] ONE = 32'h0001_0000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   mi3_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   mi3_rsp_type rsp_data;

   mi3_req_type matrix_queue[$];
   mi3_rsp_type inverse_queue[$];

   int   error_count = 0;
   int   cycle_count = 0;
   int   sent_count = 0;
   int   checked_count = 0;
   int   singular_count = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   stall_phase = 0;
   int   stall_left = 0;
   logic req_fire = 1'b0;
   logic hold_for_drain = 1'b0;
   logic drain_done = 1'b0;

   string field_name[10] = '{"inv_r0c0", "inv_r0c1", "inv_r0c2", "inv_r1c0", "inv_r1c1",
                             "inv_r1c2", "inv_r2c0", "inv_r2c1", "inv_r2c2", "determinant"};

   matrix_inverse_3x3 i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Clamp a magnitude to the signed 32-bit range and apply the sign.
   function automatic logic [31:0] clamp_signed(input logic [127:0] mag, input logic neg);
      logic [127:0] lim;
      logic [31:0]  v;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      v   = (mag > lim) ? lim[31:0] : mag[31:0];
      return neg ? (32'd0 - v) : v;
   endfunction

   // Exact adjugate inverse: one rounding step per output element.
   function automatic mi3_rsp_type invert_matrix(input mi3_req_type m);
      logic signed [127:0] a, b, c, d, e, f, g, h, i, det;
      logic signed [127:0] adj[9];
      logic [127:0]        det_mag, adj_mag, quo;
      logic [31:0]         elem[9];
      mi3_rsp_type         r;
      a = m.r0c0; b = m.r0c1; c = m.r0c2;
      d = m.r1c0; e = m.r1c1; f = m.r1c2;
      g = m.r2c0; h = m.r2c1; i = m.r2c2;
      adj[0] = e * i - f * h;
      adj[1] = c * h - b * i;
      adj[2] = b * f - c * e;
      adj[3] = f * g - d * i;
      adj[4] = a * i - c * g;
      adj[5] = c * d - a * f;
      adj[6] = d * h - e * g;
      adj[7] = b * g - a * h;
      adj[8] = a * e - b * d;
      det = a * adj[0] + b * adj[3] + c * adj[6];
      det_mag = det < 0 ? -det : det;
      r = '0;
      if (det_mag == 0) begin
         r.singular = 1'b1;
         return r;
      end
      r.determinant = clamp_signed((det_mag + (128'd1 << (2 * FRAC_BITS - 1)))
                                   >> (2 * FRAC_BITS), det < 0);
      for (int k = 0; k < 9; k++) begin
         adj_mag = adj[k] < 0 ? -adj[k] : adj[k];
         quo = ((adj_mag << (2 * FRAC_BITS + 1)) / det_mag + 128'd1) >> 1;
         elem[k] = clamp_signed(quo, (adj[k] < 0) != (det < 0));
      end
      r.inv_r0c0 = elem[0]; r.inv_r0c1 = elem[1]; r.inv_r0c2 = elem[2];
      r.inv_r1c0 = elem[3]; r.inv_r1c1 = elem[4]; r.inv_r1c2 = elem[5];
      r.inv_r2c0 = elem[6]; r.inv_r2c1 = elem[7]; r.inv_r2c2 = elem[8];
      return r;
   endfunction

   function automatic mi3_req_type make_matrix(input logic [31:0] v[9]);
      mi3_req_type m;
      m.r0c0 = v[0]; m.r0c1 = v[1]; m.r0c2 = v[2];
      m.r1c0 = v[3]; m.r1c1 = v[4]; m.r1c2 = v[5];
      m.r2c0 = v[6]; m.r2c1 = v[7]; m.r2c2 = v[8];
      return m;
   endfunction

   // One element drawn from a mix of full-range, near-unit, edge and tiny values.
   function automatic logic [31:0] random_element(input int kind);
      logic [31:0] edges[7] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, ONE, -ONE};
      case (kind)
         0: return $urandom;
         1: return 32'($urandom_range(0, 524287)) - 32'd262144;
         2: return edges[$urandom_range(0, 6)];
         default: return 32'($urandom_range(0, 255)) - 32'd128;
      endcase
   endfunction

   function automatic mi3_req_type random_matrix();
      logic [31:0] v[9];
      int          shape;
      shape = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++) begin
         case (shape)
            0, 1, 2, 3: v[k] = random_element(1);
            4, 5:       v[k] = random_element(0);
            6:          v[k] = random_element($urandom_range(0, 3));
            default:    v[k] = random_element(3);
         endcase
      end
      // Well-conditioned matrices: a strong diagonal of a few units.
      if (shape <= 2) begin
         v[0] += ONE * $urandom_range(1, 8);
         v[4] -= ONE * $urandom_range(1, 8);
         v[8] += ONE * $urandom_range(1, 8);
      end
      // Singular matrices: a repeated row or a zero column.
      if (shape == 9) begin
         if ($urandom_range(0, 1)) begin
            v[6] = v[0]; v[7] = v[1]; v[8] = v[2];
         end else begin
            v[1] = 0; v[4] = 0; v[7] = 0;
         end
      end
      return make_matrix(v);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at result %0d: %s got %h expected %h",
               checked_count, what, got, want);
      error_count++;
   endtask

   // Directed matrices first, then random ones.
   initial begin
      logic [31:0] v[9];
      v = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
      matrix_queue.push_back(make_matrix(v));
      v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      matrix_queue.push_back(make_matrix(v));
      // Tiny nonzero determinant that rounds to zero.
      v = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      matrix_queue.push_back(make_matrix(v));
      v = '{-ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, ONE / 2};
      matrix_queue.push_back(make_matrix(v));
      v = '{32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF};
      matrix_queue.push_back(make_matrix(v));
      v = '{32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000};
      matrix_queue.push_back(make_matrix(v));
      v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
      matrix_queue.push_back(make_matrix(v));
      v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      matrix_queue.push_back(make_matrix(v));
      v = '{0, ONE, 0, ONE, 0, 0, 0, 0, ONE};
      matrix_queue.push_back(make_matrix(v));
      v = '{2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE};
      matrix_queue.push_back(make_matrix(v));
      v = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 9 * ONE};
      matrix_queue.push_back(make_matrix(v));
      v = '{1, 2, 0, 3, 1, 0, 0, 0, 32'h7FFF_FFFF};
      matrix_queue.push_back(make_matrix(v));
      v = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_3333,
            32'hCCCC_CCCC, 32'h00FF_00FF, 32'hFF00_FF00, 32'h1234_5678};
      matrix_queue.push_back(make_matrix(v));
      for (int n = 0; n < N_RANDOM; n++)
         matrix_queue.push_back(random_matrix());

      repeat (12) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      wait (matrix_queue.size() == 0 && !req_valid);
      wait (inverse_queue.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
      while (inverse_queue.size() != 0) begin
         report_mismatch("missing result", 32'd0, 32'd0);
         void'(inverse_queue.pop_front());
      end
      $display("Sent %0d matrices and checked %0d inverses, %0d of them singular,",
               sent_count, checked_count, singular_count);
      $display("with bursty input, patterned output stalls and one full drain.");
      if (error_count == 0) begin
         $display("[matrix_inverse_3x3] OK");
      end else begin
         $display("[matrix_inverse_3x3] ERROR");
      end
      $finish;
   end

   // Record accepted requests and predict their results.
   always @(posedge clock) begin
      req_fire <= req_valid && !req_stall && !reset;
      if (!reset && req_valid && !req_stall) begin
         inverse_queue.push_back(invert_matrix(req_data));
         sent_count++;
      end
   end

   // Request driver: random bursts and gaps, and one pause for a full drain.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // A stalled transaction holds its payload.
      end else if (hold_for_drain) begin
         req_valid <= 1'b0;
         if (inverse_queue.size() == 0) begin
            hold_for_drain <= 1'b0;
            drain_done <= 1'b1;
         end
      end else if (sent_count == 900 && !drain_done) begin
         hold_for_drain <= 1'b1;
         req_valid <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (matrix_queue.size() != 0) begin
         req_valid <= 1'b1;
         req_data <= matrix_queue.pop_front();
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Output stall pattern: phases of no stall, random stall and long stalls.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_phase <= $urandom_range(0, 2);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_phase)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= $urandom_range(0, 1);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Check each completed response against the oldest prediction.
   always @(posedge clock) begin
      mi3_rsp_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[matrix_inverse_3x3] ERROR");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (inverse_queue.size() == 0) begin
            report_mismatch("unexpected result", 32'd0, 32'd0);
         end else begin
            want = inverse_queue.pop_front();
            for (int k = 0; k < 10; k++)
               if (rsp_data[320 - 32 * k -: 32] !== want[320 - 32 * k -: 32])
                  report_mismatch(field_name[k], rsp_data[320 - 32 * k -: 32],
                                  want[320 - 32 * k -: 32]);
            if (rsp_data.singular !== want.singular)
               report_mismatch("singular", 32'(rsp_data.singular), 32'(want.singular));
            if (want.singular)
               singular_count++;
            checked_count++;
         end
      end
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/mi3_pkg.sv
sv/mi3_div.sv
sv/matrix_inverse_3x3.sv
tb/sv/tb.sv
